/* rtl/vzbw_pkg.sv */
// ----------------------------------------------------------------------------
// vzbw_pkg
// Shared types and codes for the varint / zig-zag byte writer.
// ----------------------------------------------------------------------------
package vzbw_pkg;

    localparam int unsigned CmdW   = 3;
    localparam int unsigned ValueW = 64;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned PosW   = 16;
    localparam int unsigned GroupW = 7;

    localparam logic [CmdW-1:0] CMD_RAW      = 3'd0;
    localparam logic [CmdW-1:0] CMD_VARINT32 = 3'd1;
    localparam logic [CmdW-1:0] CMD_VARINT64 = 3'd2;
    localparam logic [CmdW-1:0] CMD_ZIGZAG32 = 3'd3;
    localparam logic [CmdW-1:0] CMD_ZIGZAG64 = 3'd4;
    localparam logic [CmdW-1:0] CMD_CLRPOS   = 3'd5;

    localparam logic [PosW-1:0] CAPACITY_RST = 16'hFFFF;

    localparam logic       STATUS_OK       = 1'b0;
    localparam logic       STATUS_OVERFLOW = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    typedef struct packed {
        logic            load;
        logic            step;
        logic [CmdW-1:0] cmd;
    } t_shift_ctl;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             more;
    } t_shift_sts;

endpackage

/* rtl/vzbw_shift_unit.sv */
// ----------------------------------------------------------------------------
// vzbw_shift_unit
// Holds the value being encoded and shifts out one 7-bit group per step (a raw byte is output whole).
// ----------------------------------------------------------------------------
module vzbw_shift_unit (
    input  logic                        i_clk,
    input  vzbw_pkg::t_shift_ctl        i_ctl,
    input  logic [vzbw_pkg::ValueW-1:0] i_value,
    output vzbw_pkg::t_shift_sts        o_sts
);
    import vzbw_pkg::*;

    logic [ValueW-1:0] r_val;
    logic [ValueW-1:0] n_val;
    logic              r_raw;
    logic              n_raw;
    logic [31:0]       lo;
    logic [31:0]       zz32;
    logic [ValueW-1:0] zz64;
    logic [ValueW-1:0] load_val;

    always_comb begin
        lo   = i_value[31:0];
        zz32 = {lo[30:0], 1'b0} ^ {32{lo[31]}};
        zz64 = {i_value[ValueW-2:0], 1'b0} ^ {ValueW{i_value[ValueW-1]}};
        case (i_ctl.cmd)
            CMD_RAW:      load_val = {{(ValueW-ByteW){1'b0}}, i_value[ByteW-1:0]};
            CMD_VARINT32: load_val = {32'd0, lo};
            CMD_VARINT64: load_val = i_value;
            CMD_ZIGZAG32: load_val = {32'd0, zz32};
            CMD_ZIGZAG64: load_val = zz64;
            default:      load_val = '0;
        endcase
    end

    always_comb begin
        n_val = r_val;
        n_raw = r_raw;
        if (i_ctl.load) begin
            n_val = load_val;
            n_raw = (i_ctl.cmd == CMD_RAW);
        end else if (i_ctl.step) begin
            n_val = {{GroupW{1'b0}}, r_val[ValueW-1:GroupW]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_raw <= n_raw;
    end

    always_comb begin
        if (r_raw) begin
            o_sts.more      = 1'b0;
            o_sts.data_byte = r_val[ByteW-1:0];
        end else begin
            o_sts.more      = (r_val[ValueW-1:GroupW] != '0);
            o_sts.data_byte = {o_sts.more, r_val[GroupW-1:0]};
        end
    end

endmodule

/* rtl/vzbw_seq.sv */
// ----------------------------------------------------------------------------
// vzbw_seq
// Sequencer: command decode, write position, capacity check, result register.
// ----------------------------------------------------------------------------
module vzbw_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [vzbw_pkg::CmdW-1:0]   i_cmd,
    input  logic                        i_cfg_we,
    input  logic [vzbw_pkg::PosW-1:0]   i_cfg_data,
    output vzbw_pkg::t_shift_ctl        o_ctl,
    input  vzbw_pkg::t_shift_sts        i_sts,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [vzbw_pkg::ByteW-1:0]  o_data_byte,
    output logic                        o_byte_valid,
    output logic [vzbw_pkg::PosW-1:0]   o_position,
    output logic                        o_last,
    output logic                        o_status
);
    import vzbw_pkg::*;

    t_state           r_state, n_state;
    logic [PosW-1:0]  r_count, n_count;
    logic [PosW-1:0]  r_cap, n_cap;
    logic             r_ovalid, n_ovalid;
    logic [ByteW-1:0] r_byte, n_byte;
    logic             r_bvalid, n_bvalid;
    logic [PosW-1:0]  r_pos, n_pos;
    logic             r_last, n_last;
    logic             r_stat, n_stat;
    logic             accept;
    logic             slot;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot       = !r_ovalid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cap    = i_cfg_we ? i_cfg_data : r_cap;
        n_ovalid = r_ovalid && !i_out_ready;
        n_byte   = r_byte;
        n_bvalid = r_bvalid;
        n_pos    = r_pos;
        n_last   = r_last;
        n_stat   = r_stat;
        o_ctl.load = 1'b0;
        o_ctl.step = 1'b0;
        o_ctl.cmd  = i_cmd;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_CLRPOS) begin
                        n_count = '0;
                    end else if (i_cmd <= CMD_ZIGZAG64) begin
                        o_ctl.load = 1'b1;
                        n_state    = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (slot) begin
                    n_ovalid = 1'b1;
                    n_pos    = r_count;
                    if (r_count >= r_cap) begin
                        n_byte   = '0;
                        n_bvalid = 1'b0;
                        n_last   = 1'b1;
                        n_stat   = STATUS_OVERFLOW;
                        n_state  = S_IDLE;
                    end else begin
                        n_byte     = i_sts.data_byte;
                        n_bvalid   = 1'b1;
                        n_last     = !i_sts.more;
                        n_stat     = STATUS_OK;
                        n_count    = r_count + 1'b1;
                        o_ctl.step = 1'b1;
                        if (!i_sts.more) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cap    <= CAPACITY_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cap    <= n_cap;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_bvalid <= n_bvalid;
        r_pos    <= n_pos;
        r_last   <= n_last;
        r_stat   <= n_stat;
    end

    assign o_out_valid  = r_ovalid;
    assign o_data_byte  = r_byte;
    assign o_byte_valid = r_bvalid;
    assign o_position   = r_pos;
    assign o_last       = r_last;
    assign o_status     = r_stat;

endmodule

/* rtl/varint_zigzag_byte_writer_unit.sv */
// ----------------------------------------------------------------------------
// varint_zigzag_byte_writer_unit
// Writes raw bytes, unsigned varints and zig-zag varints with a bounded
// write position.
// ----------------------------------------------------------------------------
// The input beat loads the shift unit; the first result beat is registered from it once the output register is free.
// Throughput: one result beat per cycle from the shared 7-bit shift unit while
//   the output is not stalled; an encoding command holds the input until its last beat is registered.
// Position clear and unused commands give no beat.
// Reset (synchronous, active low): position 0, capacity 65535, output empty.
// ----------------------------------------------------------------------------
module varint_zigzag_byte_writer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [vzbw_pkg::CmdW-1:0]   i_cmd,
    input  logic [vzbw_pkg::ValueW-1:0] i_value,
    input  logic                        i_cfg_we,
    input  logic [vzbw_pkg::PosW-1:0]   i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [vzbw_pkg::ByteW-1:0]  o_data_byte,
    output logic                        o_byte_valid,
    output logic [vzbw_pkg::PosW-1:0]   o_position,
    output logic                        o_last,
    output logic                        o_status
);
    import vzbw_pkg::*;

    t_shift_ctl ctl;
    t_shift_sts sts;

    vzbw_shift_unit u_shift (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_value (i_value),
        .o_sts   (sts)
    );

    vzbw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_ctl        (ctl),
        .i_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_position   (o_position),
        .o_last       (o_last),
        .o_status     (o_status)
    );

endmodule

/* verif/tb_varint_zigzag_byte_writer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_varint_zigzag_byte_writer_unit
// Self-checking bench for the varint / zig-zag byte writer. A queue-fed
// driver sends commands, each accepted command is encoded by a bench-side
// copy of the writer (position and capacity included), and a monitor checks
// every output beat field by field. Capacity is changed between phases,
// from zero to full, so that overflow cases are covered.
// ----------------------------------------------------------------------------
module tb_varint_zigzag_byte_writer_unit;
    import vzbw_pkg::*;

    localparam logic [CmdW-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CmdW-1:0] CMD_SPARE7 = 3'd7;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [CmdW-1:0]   cmd;
        logic [ValueW-1:0] value;
    } t_cmd_item;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             byte_valid;
        logic [PosW-1:0]  position;
        logic             last;
        logic             status;
    } t_wr_beat;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [CmdW-1:0]     i_cmd        = '0;
    logic [ValueW-1:0]   i_value      = '0;
    logic                i_cfg_we     = 1'b0;
    logic [PosW-1:0]     i_cfg_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [ByteW-1:0]    o_data_byte;
    logic                o_byte_valid;
    logic [PosW-1:0]     o_position;
    logic                o_last;
    logic                o_status;

    t_cmd_item   pending_cmds[$];
    t_wr_beat    expected_beats[$];
    logic [PosW-1:0] capacity_copy = CAPACITY_RST;
    logic [PosW-1:0] write_pos     = '0;
    bit          idle_en      = 1'b1;
    int          in_gap       = 0;
    int          out_stall    = 0;
    int          mismatch_cnt = 0;
    t_cmd_item   next_cmd;
    t_wr_beat    got_beat;
    t_wr_beat    want_beat;

    varint_zigzag_byte_writer_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_data_byte  (o_data_byte),
        .o_byte_valid (o_byte_valid),
        .o_position   (o_position),
        .o_last       (o_last),
        .o_status     (o_status)
    );

    always #1 i_clk = ~i_clk;

    task automatic push_encoded(input logic [ValueW-1:0] v, input bit raw);
        logic [ValueW-1:0] rest;
        logic [ByteW-1:0]  b;
        bit                more;
        bit                done;
        done = 1'b0;
        while (!done) begin
            if (write_pos >= capacity_copy) begin
                expected_beats.push_back('{'0, 1'b0, write_pos, 1'b1, STATUS_OVERFLOW});
                done = 1'b1;
            end else begin
                if (raw) begin
                    b    = v[ByteW-1:0];
                    more = 1'b0;
                end else begin
                    rest = v >> GroupW;
                    more = (rest != '0);
                    b    = {more, v[GroupW-1:0]};
                    v    = rest;
                end
                expected_beats.push_back('{b, 1'b1, write_pos, !more, STATUS_OK});
                write_pos = write_pos + 1'b1;
                if (!more) done = 1'b1;
            end
        end
    endtask

    task automatic predict_encoding(input logic [CmdW-1:0] cmd,
                                    input logic [ValueW-1:0] value);
        logic [31:0] lo;
        lo = value[31:0];
        case (cmd)
            CMD_RAW:      push_encoded({56'd0, value[7:0]}, 1'b1);
            CMD_VARINT32: push_encoded({32'd0, lo}, 1'b0);
            CMD_VARINT64: push_encoded(value, 1'b0);
            CMD_ZIGZAG32: push_encoded({32'd0, {lo[30:0], 1'b0} ^ {32{lo[31]}}}, 1'b0);
            CMD_ZIGZAG64: push_encoded({value[62:0], 1'b0} ^ {64{value[63]}}, 1'b0);
            CMD_CLRPOS:   write_pos = '0;
            default: ;
        endcase
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_encoding(i_cmd, i_value);
            if (!i_in_valid || o_in_ready) begin
                if (in_gap == 0 && idle_en && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 10);
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    next_cmd = pending_cmds.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd      <= next_cmd.cmd;
                    i_value    <= next_cmd.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_beat = '{o_data_byte, o_byte_valid, o_position, o_last, o_status};
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none actual %0h",
                             $time, got_beat);
                    mismatch_cnt++;
                end else begin
                    want_beat = expected_beats.pop_front();
                    check_field("data_byte", 64'(want_beat.data_byte),
                                64'(got_beat.data_byte));
                    check_field("byte_valid", 64'(want_beat.byte_valid),
                                64'(got_beat.byte_valid));
                    check_field("position", 64'(want_beat.position),
                                64'(got_beat.position));
                    check_field("last", 64'(want_beat.last), 64'(got_beat.last));
                    check_field("status", 64'(want_beat.status), 64'(got_beat.status));
                end
            end
            if (out_stall == 0 && idle_en && $urandom_range(0, 7) == 0)
                out_stall = $urandom_range(1, 10);
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic add_cmd(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] value);
        pending_cmds.push_back('{cmd, value});
    endtask

    function automatic logic [ValueW-1:0] rand_value();
        logic [ValueW-1:0] v;
        int                w;
        v = {$urandom, $urandom};
        w = $urandom_range(0, 64);
        if (w < 64) v = v & ((64'd1 << w) - 64'd1);
        if ($urandom_range(0, 3) == 0) v = ~v;
        return v;
    endfunction

    function automatic logic [CmdW-1:0] rand_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CMD_RAW;
        if (r < 30) return CMD_VARINT32;
        if (r < 50) return CMD_VARINT64;
        if (r < 70) return CMD_ZIGZAG32;
        if (r < 90) return CMD_ZIGZAG64;
        if (r < 96) return CMD_CLRPOS;
        return (r < 98) ? CMD_SPARE6 : CMD_SPARE7;
    endfunction

    task automatic add_random(input int n);
        repeat (n) add_cmd(rand_cmd(), rand_value());
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || i_in_valid || expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [PosW-1:0] c);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        capacity_copy = c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_cmd(CMD_RAW,      64'h0);
        add_cmd(CMD_RAW,      64'hFFFF_FFFF_FFFF_FFFF);
        add_cmd(CMD_RAW,      64'h1234_5678_9ABC_DE80);
        add_cmd(CMD_VARINT32, 64'h0);
        add_cmd(CMD_VARINT32, 64'h7F);
        add_cmd(CMD_VARINT32, 64'h80);
        add_cmd(CMD_VARINT32, 64'hA5A5_A5A5_FFFF_FFFF);
        add_cmd(CMD_VARINT64, 64'h0);
        add_cmd(CMD_VARINT64, 64'h8000_0000_0000_0000);
        add_cmd(CMD_VARINT64, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cmd(CMD_ZIGZAG32, 64'h0);
        add_cmd(CMD_ZIGZAG32, 64'h0000_0000_FFFF_FFFF);
        add_cmd(CMD_ZIGZAG32, 64'hFFFF_FFFF_0000_0001);
        add_cmd(CMD_ZIGZAG32, 64'h0000_0000_7FFF_FFFF);
        add_cmd(CMD_ZIGZAG32, 64'h0000_0000_8000_0000);
        add_cmd(CMD_ZIGZAG64, 64'h0);
        add_cmd(CMD_ZIGZAG64, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cmd(CMD_ZIGZAG64, 64'h7FFF_FFFF_FFFF_FFFF);
        add_cmd(CMD_ZIGZAG64, 64'h8000_0000_0000_0000);
        add_cmd(CMD_SPARE6,   64'hFFFF_FFFF_FFFF_FFFF);
        add_cmd(CMD_SPARE7,   64'h1);
        add_cmd(CMD_CLRPOS,   64'h0);
        add_cmd(CMD_VARINT32, 64'h3FFF);
        drain();

        set_capacity(16'd0);
        add_random(10);
        drain();

        set_capacity(16'd1);
        add_cmd(CMD_CLRPOS, 64'h0);
        add_random(10);
        drain();

        set_capacity(16'hFFFF);
        add_random(30);
        drain();

        // capacity drops below the current position
        set_capacity(16'd3);
        add_random(10);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            idle_en = ($urandom_range(0, 3) != 0);
            set_capacity(16'($urandom_range(0, 60)));
            if ($urandom_range(0, 1) == 0) add_cmd(CMD_CLRPOS, rand_value());
            add_random(40);
            drain();
        end

        idle_en = 1'b0;
        set_capacity(16'hFFFE);
        add_cmd(CMD_CLRPOS, 64'h0);
        add_random(40);
        drain();

        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
